// File: design/bde_pkg.sv
// Shared definitions for the byte deque engine: operation codes, result
// status codes and the default ring depth.
// No dependencies; byte_deque_engine_core imports this package.
`default_nettype none

package bde_pkg;

	// Default number of byte slots in the ring.
	localparam int DEPTH_DEF = 32;

	// Operation requested by an input item.
	typedef enum logic [2:0] {
		K_PUSH_FRONT = 3'd0,
		K_PUSH_BACK  = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_BACK   = 3'd3,
		K_DUMP       = 3'd4
	} kind_t;

	// Status carried with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage : bde_pkg

`default_nettype wire

// File: design/bde_ram.sv
// Byte storage of the deque: one write port and one read port with a
// registered read.
// Depends on nothing but its parameters.
`default_nettype none

module bde_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data_q
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule : bde_ram

`default_nettype wire

// File: design/byte_deque_engine_core.sv
// Top level of the byte deque engine: command decode, ring pointers, the
// dump walker and the result registers, around the bde_ram storage.
// Depends on bde_pkg and bde_ram.
//
//   Channel   Ports                      Handshake
//   -------   ------------------------   ---------------------------------------
//   command   start, busy, kind, value   item taken at a clock edge with start
//                                        high and busy low
//   result    strobe, status, data, last a result is valid while strobe is high;
//                                        the receiver always takes it
//
// Sequencing: a push is done as it is taken and the next item can be taken in the
// following cycle. A pop passes through S_POP, waiting there for the registered
// read of the storage memory. A dump walks the entries in S_DUMP: the single read
// port delivers one entry per cycle after the registered read of the first entry.
// A status-only result (full, empty) is registered straight from the idle state.
// Reset: arst_n clears the front pointer, the occupancy count, the state and
// the strobe; the byte storage itself is not cleared and is only ever read
// at slots that a push has written.
// Stalls: busy is high while a pop or dump is in progress; results are never
// held back because the receiver cannot stall.
`default_nettype none

module byte_deque_engine_core #(
	parameter int DEPTH = bde_pkg::DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [2:0]       kind,
	input  wire logic [7:0]       value,
	output logic                  strobe,
	output bde_pkg::status_t      status,
	output logic      [7:0]       data,
	output logic                  last
);

	import bde_pkg::*;

	// Slot index width and occupancy count width (the count must hold DEPTH).
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);

	// Control states, one-hot.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_POP  = 3'b010,
		S_DUMP = 3'b100
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   front_q;     // slot of the front entry
	logic [CW-1:0]   occ_q;       // number of stored entries
	logic [AW-1:0]   slot_q;      // slot being read during a dump
	logic [CW-1:0]   rem_q;       // dump results still to give, current one included
	logic            strobe_q;
	status_t         status_q;
	logic [7:0]      data_q;
	logic            last_q;

	logic            take;
	logic            is_full;
	logic            is_empty;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [7:0]      rd_data;

	// Ring arithmetic. Slots run from 0 to DEPTH-1, which need not be a power
	// of two, so wrapping is an explicit compare against the depth.
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - AW'(1);
	endfunction

	// Base plus an offset of at most DEPTH stays below twice the depth, so one
	// conditional subtract brings it back into range.
	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW + 1)'(base) + (CW + 1)'(off);
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	assign busy     = (state_q != S_IDLE);
	assign take     = start && (state_q == S_IDLE);
	assign is_full  = (occ_q == FULL_CNT);
	assign is_empty = (occ_q == '0);

	// Storage access. Writes happen only for pushes and reads only for pops
	// and dumps, so a read and a write never meet in the same cycle; a read in
	// a later cycle sees any earlier write without forwarding.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_add(front_q, occ_q);
		rd_en   = 1'b0;
		rd_addr = front_q;
		unique case (1'b1)
			state_q[0]: begin
				if (take) begin
					if (kind == K_PUSH_FRONT) begin
						// The new front slot is the one just before the current front.
						wr_en   = !is_full;
						wr_addr = slot_dec(front_q);
					end else if (kind == K_PUSH_BACK) begin
						wr_en   = !is_full;
					end else if (kind == K_POP_FRONT || kind == K_DUMP) begin
						rd_en   = !is_empty;
					end else if (kind == K_POP_BACK) begin
						rd_en   = !is_empty;
						rd_addr = slot_add(front_q, occ_q - CW'(1));
					end
				end
			end
			state_q[1]: begin
				rd_en = 1'b0;
			end
			state_q[2]: begin
				// Fetch the next entry while the current one goes out.
				rd_en   = (rem_q != CW'(1));
				rd_addr = slot_inc(slot_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	bde_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (value),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	// Control state, ring pointers and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			occ_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (kind)
							K_PUSH_FRONT, K_PUSH_BACK: begin
								if (is_full) begin
									strobe_q <= 1'b1;
								end else begin
									occ_q <= occ_q + CW'(1);
									if (kind == K_PUSH_FRONT) begin
										front_q <= slot_dec(front_q);
									end
								end
							end
							K_POP_FRONT, K_POP_BACK: begin
								if (is_empty) begin
									strobe_q <= 1'b1;
								end else begin
									occ_q   <= occ_q - CW'(1);
									state_q <= S_POP;
									if (kind == K_POP_FRONT) begin
										front_q <= slot_inc(front_q);
									end
								end
							end
							K_DUMP: begin
								if (is_empty) begin
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								// Unused codes are dropped without a result.
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_POP: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_DUMP: begin
					strobe_q <= 1'b1;
					if (rem_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Dump walker and result payload; these need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				slot_q   <= front_q;
				rem_q    <= occ_q;
				data_q   <= '0;
				last_q   <= 1'b1;
				// A status-only result is full for a push and empty otherwise.
				status_q <= (is_full && (kind == K_PUSH_FRONT || kind == K_PUSH_BACK)) ?
				            ST_FULL : ST_EMPTY;
			end
			S_POP: begin
				status_q <= ST_OK;
				data_q   <= rd_data;
				last_q   <= 1'b1;
			end
			S_DUMP: begin
				status_q <= ST_OK;
				data_q   <= rd_data;
				last_q   <= (rem_q == CW'(1));
				rem_q    <= rem_q - CW'(1);
				slot_q   <= slot_inc(slot_q);
			end
			default: begin
				last_q <= 1'b1;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

endmodule : byte_deque_engine_core

`default_nettype wire
